[src/salc_pkg.sv]
// Shared types and constants of the set-associative LRU tag directory.
// No dependencies; used by salc_lookup, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

   localparam int WAYS         = 8;
   localparam int MAX_SET_BITS = 6;
   localparam int ADDR_WIDTH   = 32;

   localparam int SETS   = 1 << MAX_SET_BITS;
   localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_W = WAY_W;
   localparam int NWAY_W = $clog2(WAYS + 1);
   localparam int SB_W   = 4;
   localparam int SHIFT_W = 6;

   localparam logic [RANK_W-1:0] MAX_RANK = RANK_W'(WAYS - 1);

   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_FILL  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   localparam logic [1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS        = 2'd2;

   typedef struct packed {
      logic                  valid;
      logic [ADDR_WIDTH-1:0] tag;
      logic [RANK_W-1:0]     rank;
   } line_type;

   typedef line_type [WAYS-1:0] row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      logic       hit;
      logic       evict;
      logic [1:0] outcome;
   } look_type;

endpackage

`default_nettype wire

[src/salc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                              wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output      logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/salc_lookup.sv]
// Tag compare, victim choice and LRU rank update for one set row.
// Depends on salc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module salc_lookup
   import salc_pkg::*;
(
   input  wire row_type                 row_in,
   input  wire logic [ADDR_WIDTH-1:0]   tag_in,
   input  wire logic [NWAY_W-1:0]       nways_in,
   output      row_type                 row_out,
   output      look_type                look
);

   logic [WAYS-1:0]   in_use;
   logic [WAYS-1:0]   hit_vec;
   logic [WAYS-1:0]   free_vec;
   logic              hit;
   logic              free;
   logic [WAY_W-1:0]  hit_way;
   logic [WAY_W-1:0]  free_way;
   logic [WAY_W-1:0]  victim;
   logic [RANK_W-1:0] old_max;
   logic [WAY_W-1:0]  sel_way;
   logic [RANK_W:0]   old_rank;

   always_comb begin
      hit      = 1'b0;
      free     = 1'b0;
      hit_way  = '0;
      free_way = '0;
      for (int i = 0; i < WAYS; i++) begin
         in_use[i]   = (NWAY_W'(i) < nways_in);
         hit_vec[i]  = in_use[i] && row_in[i].valid && (row_in[i].tag == tag_in);
         free_vec[i] = in_use[i] && !row_in[i].valid;
      end
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit     = 1'b1;
            hit_way = WAY_W'(i);
         end
         if (free_vec[i]) begin
            free     = 1'b1;
            free_way = WAY_W'(i);
         end
      end

      // oldest line, lowest way wins a tie
      victim  = '0;
      old_max = row_in[0].rank;
      for (int i = 1; i < WAYS; i++) begin
         if (in_use[i] && (row_in[i].rank > old_max)) begin
            victim  = WAY_W'(i);
            old_max = row_in[i].rank;
         end
      end

      if (hit) begin
         sel_way  = hit_way;
         old_rank = {1'b0, row_in[hit_way].rank};
         look     = '{hit: 1'b1, evict: 1'b0, outcome: OUT_HIT};
      end else if (free) begin
         sel_way  = free_way;
         old_rank = (RANK_W + 1)'(WAYS);
         look     = '{hit: 1'b0, evict: 1'b0, outcome: OUT_FILL};
      end else begin
         sel_way  = victim;
         old_rank = {1'b0, old_max};
         look     = '{hit: 1'b0, evict: 1'b1, outcome: OUT_EVICT};
      end

      row_out = row_in;
      for (int i = 0; i < WAYS; i++) begin
         if (in_use[i] && (WAY_W'(i) != sel_way) && row_in[i].valid &&
             ({1'b0, row_in[i].rank} < old_rank) && (row_in[i].rank != MAX_RANK)) begin
            row_out[i].rank = row_in[i].rank + 1'b1;
         end
      end
      row_out[sel_way].valid = 1'b1;
      row_out[sel_way].tag   = tag_in;
      row_out[sel_way].rank  = '0;
   end

endmodule

`default_nettype wire

[src/set_assoc_lru_cache_tags.sv]
// Top level of the set-associative LRU tag directory: config, sequencer, counters.
// Depends on salc_pkg, salc_ram and salc_lookup.
`timescale 1ns / 1ps
`default_nettype none

// Each address takes two steps: read the set's row (all ways' valid, tag and
// rank) from the tag RAM, then compare, update the ranks and write the row back,
// loading the result register; the second step waits while that register holds
// an untaken word. No new address is taken before the last is done. After reset
// the block clears all SETS (64) rows of the tag RAM before it takes its first
// address; configuration writes are taken at any time. Configuration is to be
// written only while the block is idle; the block itself does not enforce this.
module set_assoc_lru_cache_tags
   import salc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [ADDR_WIDTH-1:0] req_address,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [1:0]            rsp_outcome,
   output      logic [31:0]           rsp_hit_total,
   output      logic [31:0]           rsp_miss_total,
   output      logic [31:0]           rsp_evict_total,
   input  wire logic                  csr_wr_en,
   input  wire logic [1:0]            csr_index,
   input  wire logic [4:0]            csr_wr_data
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK
   } state_type;

   state_type             state_ff, state_in;
   logic [SET_W-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [SET_W-1:0]      set_ff, set_in;
   logic [ADDR_WIDTH-1:0] tag_ff, tag_in;
   logic [2:0]            cfg_sets_ff, cfg_sets_in;
   logic [4:0]            cfg_offset_ff, cfg_offset_in;
   logic [3:0]            cfg_ways_ff, cfg_ways_in;
   logic [31:0]           hits_ff, hits_in;
   logic [31:0]           misses_ff, misses_in;
   logic [31:0]           evicts_ff, evicts_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_outcome_ff, rsp_outcome_in;
   logic [31:0]           rsp_hit_ff, rsp_hit_in;
   logic [31:0]           rsp_miss_ff, rsp_miss_in;
   logic [31:0]           rsp_evict_ff, rsp_evict_in;

   logic [SB_W-1:0]       set_bits_eff;
   logic [SHIFT_W-1:0]    tag_shift;
   logic [ADDR_WIDTH-1:0] set_mask;
   logic [4:0]            ways_ext;
   logic [NWAY_W-1:0]     nways;
   logic                  accept;
   logic                  look_fire;
   logic                  ram_we;
   logic [SET_W-1:0]      ram_wr_addr;
   logic [SET_W-1:0]      ram_rd_addr;
   row_type               ram_wr_row;
   row_type               ram_rd_row;
   row_type               new_row;
   look_type              look;

   assign set_bits_eff = ({1'b0, cfg_sets_ff} > SB_W'(MAX_SET_BITS)) ?
                         SB_W'(MAX_SET_BITS) : {1'b0, cfg_sets_ff};
   assign tag_shift    = SHIFT_W'(cfg_offset_ff) + SHIFT_W'(set_bits_eff);
   assign set_mask     = ~({ADDR_WIDTH{1'b1}} << set_bits_eff);
   assign ways_ext     = {1'b0, cfg_ways_ff};
   assign nways        = (ways_ext == 5'd0)       ? NWAY_W'(1) :
                         (ways_ext > 5'(WAYS))    ? NWAY_W'(WAYS) :
                                                    NWAY_W'(ways_ext);

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign look_fire = (state_ff == S_LOOK) && (!rsp_valid_ff || rsp_ready);

   assign ram_we      = (state_ff == S_CLEAR) || look_fire;
   assign ram_wr_addr = (state_ff == S_CLEAR) ? clr_cnt_ff : set_ff;
   assign ram_wr_row  = (state_ff == S_CLEAR) ? '0 : new_row;
   assign ram_rd_addr = (state_ff == S_IDLE) ? set_in : set_ff;

   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_row),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_row)
   );

   salc_lookup u_lookup (
      .row_in   (ram_rd_row),
      .tag_in   (tag_ff),
      .nways_in (nways),
      .row_out  (new_row),
      .look     (look)
   );

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      set_in         = SET_W'((req_address >> cfg_offset_ff) & set_mask);
      tag_in         = tag_ff;
      cfg_sets_in    = cfg_sets_ff;
      cfg_offset_in  = cfg_offset_ff;
      cfg_ways_in    = cfg_ways_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      evicts_in      = evicts_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_miss_in    = rsp_miss_ff;
      rsp_evict_in   = rsp_evict_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SET_BITS:    cfg_sets_in   = csr_wr_data[2:0];
            CSR_OFFSET_BITS: cfg_offset_in = csr_wr_data;
            CSR_WAYS:        cfg_ways_in   = csr_wr_data[3:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SET_W'(SETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               tag_in   = req_address >> tag_shift;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            set_in = set_ff;
            if (look_fire) begin
               hits_in        = hits_ff + 32'(look.hit);
               misses_in      = misses_ff + 32'(!look.hit);
               evicts_in      = evicts_ff + 32'(look.evict);
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = look.outcome;
               rsp_hit_in     = hits_ff + 32'(look.hit);
               rsp_miss_in    = misses_ff + 32'(!look.hit);
               rsp_evict_in   = evicts_ff + 32'(look.evict);
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         cfg_sets_ff   <= 3'd4;
         cfg_offset_ff <= 5'd4;
         cfg_ways_ff   <= 4'd8;
         hits_ff       <= '0;
         misses_ff     <= '0;
         evicts_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         cfg_sets_ff   <= cfg_sets_in;
         cfg_offset_ff <= cfg_offset_in;
         cfg_ways_ff   <= cfg_ways_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         evicts_ff     <= evicts_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      set_ff         <= set_in;
      tag_ff         <= tag_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_miss_ff    <= rsp_miss_in;
      rsp_evict_ff   <= rsp_evict_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_hit_total   = rsp_hit_ff;
   assign rsp_miss_total  = rsp_miss_ff;
   assign rsp_evict_total = rsp_evict_ff;

   a_fire_loads_word: assert property (@(posedge clock) disable iff (reset)
      look_fire |=> rsp_valid_ff)
      else $error("finished lookup did not load the result word");

   a_one_count_per_word: assert property (@(posedge clock) disable iff (reset)
      look_fire |=> (32'(hits_ff + misses_ff) == 32'($past(hits_ff + misses_ff) + 32'd1)))
      else $error("hit and miss totals did not advance by one");

   a_evict_is_miss: assert property (@(posedge clock) disable iff (reset)
      (look_fire && look.evict) |-> !look.hit)
      else $error("eviction flagged on a hit");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !ram_we || (ram_wr_row == '0))
      else $error("nonzero row written during clearing pass");

endmodule

`default_nettype wire

[verif/tb_set_assoc_lru_cache_tags.sv]
// Testbench for set_assoc_lru_cache_tags: a queued driver and a clocked monitor check every
// response word against a built-in LRU tag directory model over several cache geometries.
// Depends on salc_pkg and the set_assoc_lru_cache_tags RTL.
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_tags
   import salc_pkg::*;
();

   localparam int LINES       = SETS * WAYS;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_CYCLES = 500;
   localparam int HOLD_AT     = 400;

   typedef struct {
      logic [1:0]  outcome;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] evictions;
   } access_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [ADDR_WIDTH-1:0] req_address = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_outcome;
   logic [31:0]           rsp_hit_total;
   logic [31:0]           rsp_miss_total;
   logic [31:0]           rsp_evict_total;
   logic                  csr_wr_en = 1'b0;
   logic [1:0]            csr_index = CSR_SET_BITS;
   logic [4:0]            csr_wr_data = '0;

   // directory model
   logic                  line_valid [LINES];
   logic [ADDR_WIDTH-1:0] line_tag   [LINES];
   logic [RANK_W-1:0]     line_rank  [LINES];
   logic [31:0]           pred_hits   = '0;
   logic [31:0]           pred_misses = '0;
   logic [31:0]           pred_evicts = '0;
   logic [2:0]            cfg_set_bits    = 3'd4;
   logic [4:0]            cfg_offset_bits = 5'd4;
   logic [3:0]            cfg_ways        = 4'd8;

   access_result_type     expected_results [$];
   logic [ADDR_WIDTH-1:0] pending_addresses [$];

   int          addr_pushed = 0;
   int          addr_taken  = 0;
   int          rsp_seen    = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          req_gap_left = 0;
   int          rsp_stall_left = 0;
   int          hold_left = 0;
   bit          held = 1'b0;
   bit          req_fired = 1'b0;
   bit          quiet_mode = 1'b0;
   logic [31:0] tag_base = '0;

   set_assoc_lru_cache_tags i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_address     (req_address),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_outcome     (rsp_outcome),
      .rsp_hit_total   (rsp_hit_total),
      .rsp_miss_total  (rsp_miss_total),
      .rsp_evict_total (rsp_evict_total),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < LINES; i++) begin
         line_valid[i] = 1'b0;
         line_tag[i]   = '0;
         line_rank[i]  = '0;
      end
   end

   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   function automatic int unsigned eff_set_bits();
      return (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
   endfunction

   function automatic int unsigned eff_ways();
      if (cfg_ways < 1) return 1;
      if (cfg_ways > WAYS) return WAYS;
      return cfg_ways;
   endfunction

   // younger lines than old_rank age by one, way w becomes most recent
   function automatic void age_set(input int unsigned base, input int unsigned nways,
                                   input int unsigned w, input int unsigned old_rank);
      int unsigned k;
      for (int unsigned i = 0; i < nways; i++) begin
         k = base + i;
         if (i != w && line_valid[k] && line_rank[k] < old_rank && line_rank[k] < MAX_RANK)
            line_rank[k] = line_rank[k] + 1'b1;
      end
      line_rank[base + w] = '0;
   endfunction

   function automatic void predict_access(input logic [ADDR_WIDTH-1:0] addr);
      int unsigned    sb;
      int unsigned    off;
      int unsigned    nways;
      int unsigned    base;
      int unsigned    setv;
      int unsigned    w;
      int unsigned    oldest;
      logic [63:0]    a64;
      logic [ADDR_WIDTH-1:0] tagv;
      bit             found;
      access_result_type res;
      a64   = 64'(addr);
      off   = cfg_offset_bits;
      sb    = eff_set_bits();
      nways = eff_ways();
      setv  = int'((a64 >> off) & ((64'd1 << sb) - 64'd1));
      tagv  = ADDR_WIDTH'(a64 >> (off + sb));
      base  = setv * WAYS;
      found = 1'b0;
      w     = 0;
      for (int unsigned i = 0; i < nways; i++) begin
         if (!found && line_valid[base + i] && line_tag[base + i] == tagv) begin
            found = 1'b1;
            w = i;
         end
      end
      if (found) begin
         pred_hits = pred_hits + 1;
         age_set(base, nways, w, line_rank[base + w]);
         res.outcome = OUT_HIT;
      end else begin
         pred_misses = pred_misses + 1;
         w = nways;
         for (int unsigned i = 0; i < nways; i++)
            if (w == nways && !line_valid[base + i]) w = i;
         if (w < nways) begin
            line_valid[base + w] = 1'b1;
            line_tag[base + w]   = tagv;
            age_set(base, nways, w, WAYS);
            res.outcome = OUT_FILL;
         end else begin
            w = 0;
            oldest = line_rank[base];
            for (int unsigned i = 1; i < nways; i++) begin
               if (line_rank[base + i] > oldest) begin
                  oldest = line_rank[base + i];
                  w = i;
               end
            end
            line_tag[base + w] = tagv;
            age_set(base, nways, w, oldest);
            pred_evicts = pred_evicts + 1;
            res.outcome = OUT_EVICT;
         end
      end
      res.hits      = pred_hits;
      res.misses    = pred_misses;
      res.evictions = pred_evicts;
      expected_results.push_back(res);
   endfunction

   // mostly a small pool of tags and sets so that hits and evictions are common
   function automatic logic [ADDR_WIDTH-1:0] make_address();
      int unsigned sb;
      int unsigned off;
      int unsigned setv;
      logic [63:0] tagv;
      logic [63:0] a;
      if ($urandom_range(0, 4) == 0) return $urandom;
      sb   = eff_set_bits();
      off  = cfg_offset_bits;
      tagv = 64'(tag_base) + 64'($urandom_range(0, eff_ways() + 2));
      setv = $urandom_range(0, 3) & ((1 << sb) - 1);
      a = (tagv << (off + sb)) | (64'(setv) << off) |
          (64'($urandom) & ((64'd1 << off) - 64'd1));
      return a[ADDR_WIDTH-1:0];
   endfunction

   task automatic push_address(input logic [ADDR_WIDTH-1:0] a);
      pending_addresses.push_back(a);
      addr_pushed++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (addr_taken != addr_pushed || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [4:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
   endtask

   task automatic apply_geometry(input logic [2:0] sb, input logic [4:0] off,
                                 input logic [3:0] ways);
      write_csr(CSR_SET_BITS, 5'(sb));
      cfg_set_bits = sb;
      write_csr(CSR_OFFSET_BITS, off);
      cfg_offset_bits = off;
      write_csr(CSR_WAYS, 5'(ways));
      cfg_ways = ways;
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input logic [2:0] sb, input logic [4:0] off,
                             input logic [3:0] ways, input int count, input bit quiet);
      apply_geometry(sb, off, ways);
      quiet_mode = quiet;
      tag_base = $urandom;
      repeat (count) push_address(make_address());
      wait_drained();
      quiet_mode = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      apply_geometry(3'd4, 5'd4, 4'd8);
      push_address(32'h0000_0000);
      push_address(32'hFFFF_FFFF);
      push_address(32'h0000_000F);
      push_address(32'hFFFF_FFF0);
      for (int t = 1; t <= 8; t++) push_address(32'(t) << 8);
      push_address(32'h0000_0100);
      push_address(32'h0000_0000);
      wait_drained();

      // set bits saturate, zero ways acts as one
      apply_geometry(3'd7, 5'd0, 4'd0);
      push_address(32'h0000_0000);
      push_address(32'h0000_0040);
      push_address(32'h0000_0040);
      push_address(32'h0000_0080);
      wait_drained();

      // split reaches the top of the address, ways above the array clamp
      apply_geometry(3'd6, 5'd26, 4'd15);
      push_address(32'hFFFF_FFFF);
      push_address(32'h0400_0000);
      push_address(32'hFC00_0000);
      push_address(32'h0000_0001);
      wait_drained();

      apply_geometry(3'd0, 5'd31, 4'd8);
      push_address(32'h8000_0000);
      push_address(32'h7FFF_FFFF);
      wait_drained();

      run_random(3'd4, 5'd4,  4'd8, 300, 1'b0);
      run_random(3'd2, 5'd6,  4'd4, 250, 1'b0);
      run_random(3'd6, 5'd0,  4'd1, 200, 1'b0);
      run_random(3'd0, 5'd12, 4'd8, 200, 1'b1);
      run_random(3'd6, 5'd26, 4'd8, 150, 1'b0);
      run_random(3'd3, 5'd5,  4'd2, 200, 1'b0);
      run_random(3'd5, 5'd3,  4'd7, 250, 1'b0);

      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (req_gap_left > 0) begin
            req_valid <= 1'b0;
            req_gap_left--;
         end else if (pending_addresses.size() > 0) begin
            req_valid    <= 1'b1;
            req_address  <= pending_addresses.pop_front();
            req_gap_left = pick_gap(quiet_mode);
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_fired = 1'b0;
   end

   // long hold once, so the block backs up onto its input
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (!held && rsp_seen >= HOLD_AT) begin
         held = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall_left = pick_gap(quiet_mode);
      end
   end

   always @(posedge clock) begin : monitor
      access_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: unexpected response word outcome=%0d hits=%0d",
                           rsp_outcome, rsp_hit_total);
            end else begin
               want = expected_results.pop_front();
               if (rsp_outcome !== want.outcome || rsp_hit_total !== want.hits ||
                   rsp_miss_total !== want.misses || rsp_evict_total !== want.evictions) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("ERROR: word %0d exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              rsp_seen, want.outcome, want.hits, want.misses,
                              want.evictions, rsp_outcome, rsp_hit_total,
                              rsp_miss_total, rsp_evict_total);
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_access(req_address);
            addr_taken++;
            req_fired = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

[sim.f]
src/salc_pkg.sv
src/salc_ram.sv
src/salc_lookup.sv
src/set_assoc_lru_cache_tags.sv
verif/tb_set_assoc_lru_cache_tags.sv
